// ===== hdl/assert_macros.svh =====
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms for the log buffer RTL. Defining SYNTH
// turns every use into nothing.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTH

// The expression must hold at every clock edge outside reset.
`define ASSERT_ALWAYS(name, clk, rst_n, expr, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (expr)) \
        else $error(msg);

// When the antecedent holds, the consequent holds at the same edge.
`define ASSERT_IMPLY(name, clk, rst_n, ante, cons, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// When the antecedent holds, the consequent holds at the next edge.
`define ASSERT_NEXT(name, clk, rst_n, ante, cons, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`else

`define ASSERT_ALWAYS(name, clk, rst_n, expr, msg)
`define ASSERT_IMPLY(name, clk, rst_n, ante, cons, msg)
`define ASSERT_NEXT(name, clk, rst_n, ante, cons, msg)

`endif

`endif

// ===== hdl/pplb_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pplb_pkg
// Sizes, operation and status codes, and the types shared by the ping-pong
// packet log buffer modules.
// ----------------------------------------------------------------------------
package pplb_pkg;

    // Buffer geometry.
    localparam int CHUNK_BYTES   = 512;
    localparam int NUM_BUFFERS   = 2;
    localparam int PAYLOAD_LIMIT = 504;
    localparam int PACKET_BYTES  = 9;
    localparam int MAX_STARTS    = 2;

    localparam int BUF_BYTES = CHUNK_BYTES * NUM_BUFFERS;
    // The count byte at the end of a chunk is never covered by packet bytes.
    localparam int LIMIT = (PAYLOAD_LIMIT > CHUNK_BYTES - 1) ? CHUNK_BYTES - 1
                                                             : PAYLOAD_LIMIT;

    localparam int ADDR_W  = $clog2(BUF_BYTES);
    localparam int OFF_W   = $clog2(CHUNK_BYTES);
    localparam int CHUNK_W = $clog2(NUM_BUFFERS);
    localparam int BCNT_W  = $clog2(PACKET_BYTES);

    localparam logic [OFF_W-1:0]  COUNT_OFF = OFF_W'(CHUNK_BYTES - 1);
    localparam logic [OFF_W-1:0]  LIMIT_OFF = OFF_W'(LIMIT);
    localparam logic [OFF_W:0]    PKT_LEN   = (OFF_W + 1)'(PACKET_BYTES);
    localparam logic [BCNT_W-1:0] LAST_BYTE = BCNT_W'(PACKET_BYTES - 1);

    // Operation codes.
    localparam logic [2:0] OP_PUSH       = 3'd0;
    localparam logic [2:0] OP_SERVICE    = 3'd1;
    localparam logic [2:0] OP_WRITE_DONE = 3'd2;
    localparam logic [2:0] OP_READ       = 3'd3;
    localparam logic [2:0] OP_CLEAR      = 3'd4;

    // Push status codes.
    localparam logic [1:0] STAT_DONE     = 2'd0;
    localparam logic [1:0] STAT_NOT_FREE = 2'd1;
    localparam logic [1:0] STAT_NO_ROOM  = 2'd2;

    typedef enum logic [1:0] {
        CS_FREE      = 2'd0,
        CS_COMMITTED = 2'd1,
        CS_INTRANS   = 2'd2,
        CS_LOCKED    = 2'd3
    } cstat_t;

    typedef logic [31:0] word_t;

    typedef struct packed {
        logic [1:0] status;
        logic       write_request;
        logic       write_chunk;
        word_t      write_block;
        logic [1:0] in_flight;
        logic [7:0] read_data;
        word_t      blocks_written;
        logic       last;
    } result_t;

    // Command from the sequencer to the chunk bookkeeping.
    typedef struct packed {
        logic       commit;
        logic [2:0] op;
        logic       start_accepted;
    } chunk_cmd_t;

    // What the chunk bookkeeping reports for the item under way.
    typedef struct packed {
        logic [ADDR_W-1:0]  head;
        logic               push_ok;
        logic [1:0]         push_status;
        logic [1:0]         n_starts;
        logic [CHUNK_W-1:0] start_chunk0;
        logic [CHUNK_W-1:0] start_chunk1;
        word_t              start_blk0;
        word_t              start_blk1;
        logic [1:0]         in_flight;
        word_t              blocks_now;
        word_t              blocks_after;
        logic               rd_use_mem;
        logic [7:0]         rd_fixed;
    } chunk_view_t;

endpackage

// ===== hdl/pplb_mem.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pplb_mem
// Byte-wide packet buffer RAM, one write and one registered read per cycle.
// ----------------------------------------------------------------------------
module pplb_mem (
    input  logic                        clk,
    input  logic                        wr_en,
    input  logic [pplb_pkg::ADDR_W-1:0] wr_addr,
    input  logic [7:0]                  wr_data,
    input  logic                        rd_en,
    input  logic [pplb_pkg::ADDR_W-1:0] rd_addr,
    output logic [7:0]                  rd_data
);
    import pplb_pkg::*;

    logic [7:0] mem_array [BUF_BYTES];
    logic [7:0] rd_data_reg;

    // Read data holds until the next read is issued.
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem_array[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem_array[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

// ===== hdl/pplb_chunk.sv =====
`timescale 1ns / 1ps
`include "assert_macros.svh"
// ----------------------------------------------------------------------------
// pplb_chunk
// Chunk bookkeeping: head pointer, chunk states, packet counts, written
// marks and the committed block count, with the service sweep.
// ----------------------------------------------------------------------------
module pplb_chunk (
    input  logic                        clk,
    input  logic                        rst_n,
    input  pplb_pkg::word_t             start_block,
    input  pplb_pkg::chunk_cmd_t        cmd,
    input  logic [pplb_pkg::ADDR_W-1:0] rd_index,
    output pplb_pkg::chunk_view_t       view
);
    import pplb_pkg::*;

    logic [ADDR_W-1:0] head_reg, head_next;
    cstat_t            cstat_reg [NUM_BUFFERS];
    cstat_t            cstat_next [NUM_BUFFERS];
    logic [7:0]        cnt_reg [NUM_BUFFERS];
    logic [7:0]        cnt_next [NUM_BUFFERS];
    logic [OFF_W-1:0]  hwm_reg [NUM_BUFFERS];
    logic [OFF_W-1:0]  hwm_next [NUM_BUFFERS];
    word_t             blocks_reg, blocks_next;

    logic [CHUNK_W-1:0] hc, nc, rc;
    logic [OFF_W-1:0]   hoff, new_off, roff;
    logic [OFF_W:0]     room_end;
    logic [1:0]         push_status;
    logic               push_ok;

    cstat_t             sweep_stat [NUM_BUFFERS];
    logic               sweep_clr [NUM_BUFFERS];
    word_t              bc_run;
    logic [1:0]         nst;
    logic [1:0]         infl;
    logic [CHUNK_W-1:0] sc0, sc1;
    word_t              sb0, sb1;

    // Push check against the chunk under the head.
    always_comb
    begin
        hc       = head_reg[ADDR_W-1 -: CHUNK_W];
        nc       = hc + CHUNK_W'(1);
        hoff     = head_reg[OFF_W-1:0];
        room_end = {1'b0, hoff} + PKT_LEN;
        new_off  = hoff + PKT_LEN[OFF_W-1:0];
        if (cstat_reg[hc] != CS_FREE)
        begin
            push_status = STAT_NOT_FREE;
        end
        else if (room_end > {1'b0, LIMIT_OFF})
        begin
            push_status = STAT_NO_ROOM;
        end
        else
        begin
            push_status = STAT_DONE;
        end
        push_ok = (push_status == STAT_DONE);
    end

    // Service sweep in chunk index order.
    always_comb
    begin
        bc_run = blocks_reg;
        nst    = 2'd0;
        infl   = 2'd0;
        sc0    = '0;
        sc1    = '0;
        sb0    = '0;
        sb1    = '0;
        for (int i = 0; i < NUM_BUFFERS; i++)
        begin
            sweep_stat[i] = cstat_reg[i];
            sweep_clr[i]  = 1'b0;
            case (cstat_reg[i])
                CS_LOCKED:
                begin
                    if (cmd.start_accepted && (nst < 2'(MAX_STARTS)))
                    begin
                        sweep_stat[i] = CS_INTRANS;
                        if (nst == 2'd0)
                        begin
                            sc0 = CHUNK_W'(i);
                            sb0 = start_block + bc_run;
                        end
                        else
                        begin
                            sc1 = CHUNK_W'(i);
                            sb1 = start_block + bc_run;
                        end
                        nst = nst + 2'd1;
                    end
                end
                CS_COMMITTED:
                begin
                    bc_run        = bc_run + 32'd1;
                    sweep_stat[i] = CS_FREE;
                    sweep_clr[i]  = 1'b1;
                end
                CS_INTRANS:
                begin
                    if (infl != 2'd3)
                    begin
                        infl = infl + 2'd1;
                    end
                end
                default:
                begin
                end
            endcase
        end
    end

    // Next state on commit.
    always_comb
    begin
        head_next   = head_reg;
        blocks_next = blocks_reg;
        for (int i = 0; i < NUM_BUFFERS; i++)
        begin
            cstat_next[i] = cstat_reg[i];
            cnt_next[i]   = cnt_reg[i];
            hwm_next[i]   = hwm_reg[i];
        end
        if (cmd.commit)
        begin
            case (cmd.op)
                OP_PUSH:
                begin
                    if (push_ok)
                    begin
                        cnt_next[hc] = cnt_reg[hc] + 8'd1;
                        if (new_off > hwm_reg[hc])
                        begin
                            hwm_next[hc] = new_off;
                        end
                        if (new_off == LIMIT_OFF)
                        begin
                            cstat_next[hc] = CS_LOCKED;
                            head_next      = {nc, {OFF_W{1'b0}}};
                        end
                        else
                        begin
                            head_next = {hc, new_off};
                        end
                    end
                end
                OP_SERVICE:
                begin
                    blocks_next = bc_run;
                    for (int i = 0; i < NUM_BUFFERS; i++)
                    begin
                        cstat_next[i] = sweep_stat[i];
                        if (sweep_clr[i])
                        begin
                            cnt_next[i] = 8'd0;
                        end
                    end
                end
                OP_WRITE_DONE:
                begin
                    for (int i = 0; i < NUM_BUFFERS; i++)
                    begin
                        if (cstat_reg[i] == CS_INTRANS)
                        begin
                            cstat_next[i] = CS_COMMITTED;
                        end
                    end
                end
                OP_CLEAR:
                begin
                    head_next = '0;
                    for (int i = 0; i < NUM_BUFFERS; i++)
                    begin
                        cstat_next[i] = CS_FREE;
                        cnt_next[i]   = 8'd0;
                        hwm_next[i]   = '0;
                    end
                end
                default:
                begin
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            head_reg   <= '0;
            blocks_reg <= '0;
            for (int i = 0; i < NUM_BUFFERS; i++)
            begin
                cstat_reg[i] <= CS_FREE;
                cnt_reg[i]   <= 8'd0;
                hwm_reg[i]   <= '0;
            end
        end
        else
        begin
            head_reg   <= head_next;
            blocks_reg <= blocks_next;
            for (int i = 0; i < NUM_BUFFERS; i++)
            begin
                cstat_reg[i] <= cstat_next[i];
                cnt_reg[i]   <= cnt_next[i];
                hwm_reg[i]   <= hwm_next[i];
            end
        end
    end

    // A byte below the written mark comes from the RAM; the count byte comes
    // from its register; anything else reads as zero.
    always_comb
    begin
        rc = rd_index[ADDR_W-1 -: CHUNK_W];
        roff = rd_index[OFF_W-1:0];
        view.rd_use_mem = 1'b0;
        view.rd_fixed   = 8'd0;
        if (roff == COUNT_OFF)
        begin
            view.rd_fixed = cnt_reg[rc];
        end
        else if (roff < hwm_reg[rc])
        begin
            view.rd_use_mem = 1'b1;
        end
        view.head         = head_reg;
        view.push_ok      = push_ok;
        view.push_status  = push_status;
        view.n_starts     = nst;
        view.start_chunk0 = sc0;
        view.start_chunk1 = sc1;
        view.start_blk0   = sb0;
        view.start_blk1   = sb1;
        view.in_flight    = infl;
        view.blocks_now   = blocks_reg;
        view.blocks_after = bc_run;
    end

    `ASSERT_ALWAYS(a_head_below_limit, clk, rst_n, head_reg[OFF_W-1:0] < LIMIT_OFF, "head left the payload area")
    `ASSERT_NEXT(a_clear_head, clk, rst_n, cmd.commit && (cmd.op == OP_CLEAR), head_reg == '0, "clear did not rewind head")
    `ASSERT_NEXT(a_blocks_only_service, clk, rst_n, !(cmd.commit && (cmd.op == OP_SERVICE)), blocks_reg == $past(blocks_reg), "block count moved outside service")

endmodule

// ===== hdl/pplb_resq.sv =====
`timescale 1ns / 1ps
`include "assert_macros.svh"
// ----------------------------------------------------------------------------
// pplb_resq
// Two-entry result queue that parts the output handshake from the sequencer.
// Takes one or two results at once.
// ----------------------------------------------------------------------------
module pplb_resq (
    input  logic              clk,
    input  logic              rst_n,
    input  logic [1:0]        push_n,
    input  pplb_pkg::result_t push0,
    input  pplb_pkg::result_t push1,
    input  logic              pop,
    output pplb_pkg::result_t head,
    output logic              valid,
    output logic [1:0]        count
);
    import pplb_pkg::*;

    result_t    ent_reg [2];
    logic       wr_ptr_reg, wr_ptr_next;
    logic       rd_ptr_reg, rd_ptr_next;
    logic [1:0] cnt_reg, cnt_next;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg ^ push_n[0];
        rd_ptr_next = rd_ptr_reg ^ pop;
        cnt_next    = cnt_reg + push_n - {1'b0, pop};
    end

    always_ff @(posedge clk)
    begin
        if (push_n != 2'd0)
        begin
            ent_reg[wr_ptr_reg] <= push0;
        end
        if (push_n == 2'd2)
        begin
            ent_reg[~wr_ptr_reg] <= push1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            cnt_reg    <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

    assign head  = ent_reg[rd_ptr_reg];
    assign valid = (cnt_reg != 2'd0);
    assign count = cnt_reg;

    `ASSERT_ALWAYS(a_cnt_max, clk, rst_n, cnt_reg != 2'd3, "result queue count out of range")
    `ASSERT_IMPLY(a_pair_empty, clk, rst_n, push_n == 2'd2, cnt_reg == 2'd0, "result pair pushed into a busy queue")
    `ASSERT_IMPLY(a_no_overfill, clk, rst_n, push_n == 2'd1, cnt_reg != 2'd2, "result pushed into a full queue")

endmodule

// ===== hdl/ping_pong_packet_log_buffer_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ping_pong_packet_log_buffer_top
// Two-chunk ping-pong log buffer for nine-byte sensor packets, with block
// write bookkeeping for a storage engine.
// ----------------------------------------------------------------------------
//
//   Channel  Handshake                Payload
//   cfg      cfg_wr_en                cfg_wr_data (start block number)
//   in       in_valid / in_stall      operation, sensor_id, angle_x, angle_y,
//                                     start_accepted, read_index
//   out      out_valid / out_stall    status, write_request, write_chunk,
//                                     write_block, in_flight, read_data,
//                                     blocks_written, last
//
// A push that passes its check goes through the accept, nine byte writes into the
// byte-wide buffer RAM (one write port, one byte per cycle), and the posting of
// the result. Every other operation, and a refused push, goes straight from the
// accept to its result; a read byte uses the RAM's registered read in between.
// Reset is asynchronous and active low. The RAM needs no clearing pass: each
// chunk keeps a written mark, and bytes above it read as zero.
// A stalled output holds back the next word only while the queue lacks room; results
// wait in a two-entry queue, and a finished item waits only until the queue
// has room for all of its words.
// ----------------------------------------------------------------------------
module ping_pong_packet_log_buffer_top (
    input  logic        clk,
    input  logic        rst_n,

    input  logic        cfg_wr_en,
    input  logic [31:0] cfg_wr_data,

    input  logic        in_valid,
    output logic        in_stall,
    input  logic [2:0]  operation,
    input  logic [7:0]  sensor_id,
    input  logic [31:0] angle_x,
    input  logic [31:0] angle_y,
    input  logic        start_accepted,
    input  logic [9:0]  read_index,

    output logic        out_valid,
    input  logic        out_stall,
    output logic [1:0]  status,
    output logic        write_request,
    output logic        write_chunk,
    output logic [31:0] write_block,
    output logic [1:0]  in_flight,
    output logic [7:0]  read_data,
    output logic [31:0] blocks_written,
    output logic        last
);
    import pplb_pkg::*;

    // Sequencer states.
    typedef enum logic [2:0] {
        S_IDLE  = 3'b001,
        S_WRITE = 3'b010,
        S_RESP  = 3'b100
    } fsm_t;

    // Byte k of the packet: sensor id, then both angle words little-endian.
    function automatic logic [7:0] pkt_byte(input logic [BCNT_W-1:0] k,
                                            input logic [7:0]        sid,
                                            input word_t             ax,
                                            input word_t             ay);
        logic [7:0] b;
        case (k)
            BCNT_W'(0): b = sid;
            BCNT_W'(1): b = ax[7:0];
            BCNT_W'(2): b = ax[15:8];
            BCNT_W'(3): b = ax[23:16];
            BCNT_W'(4): b = ax[31:24];
            BCNT_W'(5): b = ay[7:0];
            BCNT_W'(6): b = ay[15:8];
            BCNT_W'(7): b = ay[23:16];
            BCNT_W'(8): b = ay[31:24];
            default:    b = 8'd0;
        endcase
        return b;
    endfunction

    fsm_t              state_reg, state_next;
    logic [BCNT_W-1:0] bcnt_reg, bcnt_next;
    word_t             start_block_reg;

    // The accepted word, held while it is worked on.
    logic [2:0]        op_reg;
    logic [7:0]        sid_reg;
    word_t             ax_reg;
    word_t             ay_reg;
    logic              acc_reg;
    logic [ADDR_W-1:0] ridx_reg;

    logic              in_accept;
    chunk_cmd_t        cmd;
    chunk_view_t       view;

    logic              mem_we;
    logic              mem_re;
    logic [ADDR_W-1:0] mem_waddr;
    logic [7:0]        mem_wdata;
    logic [7:0]        mem_rdata;

    logic [1:0]        n_res;
    logic              room;
    logic [1:0]        push_n;
    result_t           res0, res1;
    result_t           q_head;
    logic [1:0]        q_cnt;

    assign in_accept = in_valid && (state_reg == S_IDLE);
    assign in_stall  = (state_reg != S_IDLE);

    // The user must write the start block register only while idle; unenforced.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            start_block_reg <= '0;
        end
        else if (cfg_wr_en)
        begin
            start_block_reg <= cfg_wr_data;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_accept)
        begin
            op_reg   <= operation;
            sid_reg  <= sensor_id;
            ax_reg   <= angle_x;
            ay_reg   <= angle_y;
            acc_reg  <= start_accepted;
            ridx_reg <= read_index;
        end
    end

    // A service that starts two writes posts two words; everything else one.
    assign n_res = ((op_reg == OP_SERVICE) && (view.n_starts == 2'd2)) ? 2'd2 : 2'd1;
    assign room  = (q_cnt == 2'd0) || ((n_res == 2'd1) && (q_cnt == 2'd1));

    always_comb
    begin
        state_next     = state_reg;
        bcnt_next      = bcnt_reg;
        mem_we         = 1'b0;
        mem_re         = 1'b0;
        push_n         = 2'd0;
        cmd.commit     = 1'b0;
        cmd.op         = op_reg;
        cmd.start_accepted = acc_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    bcnt_next = '0;
                    // The chunk state does not change before the commit, so
                    // the push check can be taken at accept time.
                    if ((operation == OP_PUSH) && view.push_ok)
                    begin
                        state_next = S_WRITE;
                    end
                    else
                    begin
                        state_next = S_RESP;
                    end
                    if (operation == OP_READ)
                    begin
                        mem_re = 1'b1;
                    end
                end
            end
            S_WRITE:
            begin
                mem_we = 1'b1;
                if (bcnt_reg == LAST_BYTE)
                begin
                    state_next = S_RESP;
                end
                else
                begin
                    bcnt_next = bcnt_reg + BCNT_W'(1);
                end
            end
            S_RESP:
            begin
                if (room)
                begin
                    push_n     = n_res;
                    cmd.commit = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            bcnt_reg  <= '0;
        end
        else
        begin
            state_reg <= state_next;
            bcnt_reg  <= bcnt_next;
        end
    end

    // Packet bytes land at the head, which moves only at the commit.
    assign mem_waddr = view.head + ADDR_W'(bcnt_reg);
    assign mem_wdata = pkt_byte(bcnt_reg, sid_reg, ax_reg, ay_reg);

    // Result words for the item being finished.
    always_comb
    begin
        res0                = '0;
        res1                = '0;
        res0.blocks_written = view.blocks_now;
        res0.last           = 1'b1;
        case (op_reg)
            OP_PUSH:
            begin
                res0.status = view.push_status;
            end
            OP_SERVICE:
            begin
                res0.blocks_written = view.blocks_after;
                res0.in_flight      = view.in_flight;
                if (view.n_starts != 2'd0)
                begin
                    res0.write_request = 1'b1;
                    res0.write_chunk   = view.start_chunk0[0];
                    res0.write_block   = view.start_blk0;
                    res0.last          = (view.n_starts != 2'd2);
                end
                res1.blocks_written = view.blocks_after;
                res1.in_flight      = view.in_flight;
                res1.write_request  = 1'b1;
                res1.write_chunk    = view.start_chunk1[0];
                res1.write_block    = view.start_blk1;
                res1.last           = 1'b1;
            end
            OP_READ:
            begin
                res0.read_data = view.rd_use_mem ? mem_rdata : view.rd_fixed;
            end
            default:
            begin
            end
        endcase
    end

    pplb_mem u_mem (
        .clk     (clk),
        .wr_en   (mem_we),
        .wr_addr (mem_waddr),
        .wr_data (mem_wdata),
        .rd_en   (mem_re),
        .rd_addr (read_index),
        .rd_data (mem_rdata)
    );

    pplb_chunk u_chunk (
        .clk         (clk),
        .rst_n       (rst_n),
        .start_block (start_block_reg),
        .cmd         (cmd),
        .rd_index    (ridx_reg),
        .view        (view)
    );

    pplb_resq u_resq (
        .clk    (clk),
        .rst_n  (rst_n),
        .push_n (push_n),
        .push0  (res0),
        .push1  (res1),
        .pop    (out_valid && !out_stall),
        .head   (q_head),
        .valid  (out_valid),
        .count  (q_cnt)
    );

    assign status         = q_head.status;
    assign write_request  = q_head.write_request;
    assign write_chunk    = q_head.write_chunk;
    assign write_block    = q_head.write_block;
    assign in_flight      = q_head.in_flight;
    assign read_data      = q_head.read_data;
    assign blocks_written = q_head.blocks_written;
    assign last           = q_head.last;

endmodule

// ===== tb/sv/ping_pong_packet_log_buffer_top_test.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ping_pong_packet_log_buffer_top_test
// Self-checking bench for the ping-pong packet log buffer. A behavioral
// predictor of the two chunks, the head, the block count and the start block
// follows every accepted word. Results are matched in order against it while
// the channels idle and stall at random rates set per phase, over four phases.
// ----------------------------------------------------------------------------
module ping_pong_packet_log_buffer_top_test;

    import pplb_pkg::*;

    // Operation codes that the block does not use. They must leave the state
    // alone and give one result word that carries only blocks_written and last.
    localparam logic [2:0] OP_SPARE_5 = 3'd5;
    localparam logic [2:0] OP_SPARE_6 = 3'd6;
    localparam logic [2:0] OP_SPARE_7 = 3'd7;

    // With both sides stalling half the time and two result words per service, a
    // correct run stays far below this count.
    localparam int CYCLE_LIMIT      = 400000;
    localparam int DRAIN_CYCLES     = 16;
    localparam int RANDOM_PER_PHASE = 125;
    localparam int DIRECTED_ROWS    = 23;
    // Pushes that fill both chunks from empty.
    localparam int PACKETS_PER_PAIR = 2 * (LIMIT / PACKET_BYTES);

    // One input word plus, for directed rows, the result that can be read off
    // at a glance. Rows with typed cleared are checked against the predictor.
    typedef struct packed {
        logic [2:0] op;
        logic [7:0] sid;
        word_t      ax;
        word_t      ay;
        logic       acc;
        logic [9:0] ridx;
        logic       typed;
        logic [1:0] exp_status;
        logic [7:0] exp_data;
    } stim_word_t;

    // Directed part. It runs right after reset, before any block is
    // committed, so every typed row expects blocks_written to be zero.
    localparam stim_word_t DIRECTED [DIRECTED_ROWS] = '{
        // Fresh buffer: reads zero, service and write done find nothing.
        '{OP_READ,       8'h00, 32'h0000_0000, 32'h0000_0000, 1'b0, 10'd0,
          1'b1, STAT_DONE, 8'h00},
        '{OP_SERVICE,    8'h00, 32'h0000_0000, 32'h0000_0000, 1'b1, 10'd0,
          1'b1, STAT_DONE, 8'h00},
        '{OP_WRITE_DONE, 8'h00, 32'h0000_0000, 32'h0000_0000, 1'b0, 10'd0,
          1'b1, STAT_DONE, 8'h00},
        // Unused codes.
        '{OP_SPARE_5,    8'hFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b1, 10'h3FF,
          1'b1, STAT_DONE, 8'h00},
        '{OP_SPARE_6,    8'h5A, 32'hA5A5_A5A5, 32'h5A5A_5A5A, 1'b0, 10'h155,
          1'b1, STAT_DONE, 8'h00},
        '{OP_SPARE_7,    8'hA5, 32'h5A5A_5A5A, 32'hA5A5_A5A5, 1'b1, 10'h2AA,
          1'b1, STAT_DONE, 8'h00},
        // Three packets: all zero, all ones, then a byte-order pattern.
        '{OP_PUSH,       8'h00, 32'h0000_0000, 32'h0000_0000, 1'b0, 10'd0,
          1'b1, STAT_DONE, 8'h00},
        '{OP_PUSH,       8'hFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b1, 10'h3FF,
          1'b1, STAT_DONE, 8'h00},
        '{OP_PUSH,       8'hA5, 32'h1234_5678, 32'h9ABC_DEF0, 1'b0, 10'd0,
          1'b0, STAT_DONE, 8'h00},
        // Packet bytes land little-endian after the sensor id.
        '{OP_READ,       8'h00, 32'h0000_0000, 32'h0000_0000, 1'b0, 10'd0,
          1'b1, STAT_DONE, 8'h00},
        '{OP_READ,       8'h00, 32'h0000_0000, 32'h0000_0000, 1'b0, 10'd9,
          1'b1, STAT_DONE, 8'hFF},
        '{OP_READ,       8'h00, 32'h0000_0000, 32'h0000_0000, 1'b0, 10'd17,
          1'b1, STAT_DONE, 8'hFF},
        '{OP_READ,       8'h00, 32'h0000_0000, 32'h0000_0000, 1'b0, 10'd18,
          1'b1, STAT_DONE, 8'hA5},
        '{OP_READ,       8'h00, 32'h0000_0000, 32'h0000_0000, 1'b0, 10'd19,
          1'b1, STAT_DONE, 8'h78},
        '{OP_READ,       8'h00, 32'h0000_0000, 32'h0000_0000, 1'b0, 10'd23,
          1'b1, STAT_DONE, 8'hF0},
        // Packet count in the last byte of chunk 0; chunk 1 is untouched.
        '{OP_READ,       8'h00, 32'h0000_0000, 32'h0000_0000, 1'b0, 10'd511,
          1'b1, STAT_DONE, 8'h03},
        '{OP_READ,       8'h00, 32'h0000_0000, 32'h0000_0000, 1'b0, 10'd1023,
          1'b1, STAT_DONE, 8'h00},
        '{OP_READ,       8'h00, 32'h0000_0000, 32'h0000_0000, 1'b0, 10'd27,
          1'b0, STAT_DONE, 8'h00},
        '{OP_SERVICE,    8'h00, 32'h0000_0000, 32'h0000_0000, 1'b0, 10'd0,
          1'b0, STAT_DONE, 8'h00},
        // Clear wipes the buffer, so the count byte reads zero again.
        '{OP_CLEAR,      8'h00, 32'h0000_0000, 32'h0000_0000, 1'b0, 10'd0,
          1'b1, STAT_DONE, 8'h00},
        '{OP_READ,       8'h00, 32'h0000_0000, 32'h0000_0000, 1'b0, 10'd511,
          1'b1, STAT_DONE, 8'h00},
        '{OP_PUSH,       8'h5A, 32'h8000_0001, 32'h7FFF_FFFE, 1'b1, 10'd0,
          1'b0, STAT_DONE, 8'h00},
        '{OP_READ,       8'h00, 32'h0000_0000, 32'h0000_0000, 1'b0, 10'h200,
          1'b0, STAT_DONE, 8'h00}
    };

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        cfg_wr_en = 1'b0;
    word_t       cfg_wr_data = '0;
    logic        in_valid = 1'b0;
    logic        in_stall;
    logic [2:0]  operation;
    logic [7:0]  sensor_id;
    logic [31:0] angle_x;
    logic [31:0] angle_y;
    logic        start_accepted;
    logic [9:0]  read_index;
    logic        out_valid;
    logic        out_stall = 1'b0;
    logic [1:0]  status;
    logic        write_request;
    logic        write_chunk;
    logic [31:0] write_block;
    logic [1:0]  in_flight;
    logic [7:0]  read_data;
    logic [31:0] blocks_written;
    logic        last;

    // The word on offer. The payload ports follow it, so the whole word
    // changes with one assignment at the falling edge.
    stim_word_t cur_word = '0;

    assign operation      = cur_word.op;
    assign sensor_id      = cur_word.sid;
    assign angle_x        = cur_word.ax;
    assign angle_y        = cur_word.ay;
    assign start_accepted = cur_word.acc;
    assign read_index     = cur_word.ridx;

    // Percentages of cycles in which the sender idles and the receiver
    // stalls; the main sequence changes them from phase to phase.
    int in_idle_pct   = 0;
    int out_stall_pct = 0;

    int cycle_count    = 0;
    int mismatch_count = 0;
    int result_seq     = 0;

    // Predicted log buffer: bytes, head and tail, chunk states, block count
    // and the start block register.
    logic [7:0]   log_mem [BUF_BYTES];
    int           log_head;
    int           log_tail;
    cstat_t       chunk_st [NUM_BUFFERS];
    word_t        blocks_done = '0;
    word_t        first_block = '0;

    // Result words still owed by the block, oldest first.
    result_t pending_results [$];

    ping_pong_packet_log_buffer_top dut (
        .clk            (clk),
        .rst_n          (rst_n),
        .cfg_wr_en      (cfg_wr_en),
        .cfg_wr_data    (cfg_wr_data),
        .in_valid       (in_valid),
        .in_stall       (in_stall),
        .operation      (operation),
        .sensor_id      (sensor_id),
        .angle_x        (angle_x),
        .angle_y        (angle_y),
        .start_accepted (start_accepted),
        .read_index     (read_index),
        .out_valid      (out_valid),
        .out_stall      (out_stall),
        .status         (status),
        .write_request  (write_request),
        .write_chunk    (write_chunk),
        .write_block    (write_block),
        .in_flight      (in_flight),
        .read_data      (read_data),
        .blocks_written (blocks_written),
        .last           (last)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // Address of the packet count byte of a chunk.
    function automatic int count_pos(input int chunk);
        return (chunk * CHUNK_BYTES + CHUNK_BYTES - 1) % BUF_BYTES;
    endfunction

    // Empties the predicted buffer; the block count survives a clear.
    task automatic clear_log();
        for (int i = 0; i < BUF_BYTES; i++)
        begin
            log_mem[i] = 8'h00;
        end
        log_head = 0;
        log_tail = 0;
        for (int i = 0; i < NUM_BUFFERS; i++)
        begin
            chunk_st[i] = CS_FREE;
        end
    endtask

    // Advances the predicted buffer by one accepted word. When record is set
    // the result words it causes are queued as expectations.
    task automatic predict_word(input stim_word_t w, input bit record);
        int         chunk;
        int         base;
        int         offset;
        int         n_starts;
        int         infl;
        int         start_chunk [MAX_STARTS];
        word_t      start_blk [MAX_STARTS];
        logic [7:0] pkt_byte;
        result_t    r;

        r = '0;
        r.last = 1'b1;
        n_starts = 0;
        infl = 0;
        case (w.op)
            OP_PUSH:
            begin
                chunk = (log_head / CHUNK_BYTES) % NUM_BUFFERS;
                base = chunk * CHUNK_BYTES;
                offset = log_head - base;
                if (chunk_st[chunk] != CS_FREE)
                begin
                    r.status = STAT_NOT_FREE;
                end
                else if (offset > LIMIT || PACKET_BYTES > LIMIT - offset)
                begin
                    r.status = STAT_NO_ROOM;
                end
                else
                begin
                    // Sensor id, then both angles low byte first; any byte
                    // past the ninth is written as zero.
                    for (int k = 0; k < PACKET_BYTES; k++)
                    begin
                        if (k == 0)
                            pkt_byte = w.sid;
                        else if (k < 5)
                            pkt_byte = 8'(w.ax >> (8 * (k - 1)));
                        else if (k < 9)
                            pkt_byte = 8'(w.ay >> (8 * (k - 5)));
                        else
                            pkt_byte = 8'h00;
                        log_mem[log_head % BUF_BYTES] = pkt_byte;
                        log_head++;
                    end
                    log_mem[count_pos(chunk)] = log_mem[count_pos(chunk)] + 8'd1;
                    if (log_head == base + LIMIT)
                    begin
                        chunk_st[chunk] = CS_LOCKED;
                        log_head = ((chunk + 1) % NUM_BUFFERS) * CHUNK_BYTES;
                    end
                    r.status = STAT_DONE;
                end
            end
            OP_SERVICE:
            begin
                // The sweep goes in chunk order: locked chunks start a write when acc is set,
                // at the current block number, and committed ones are released.
                for (int i = 0; i < NUM_BUFFERS; i++)
                begin
                    case (chunk_st[i])
                        CS_LOCKED:
                        begin
                            if (w.acc && n_starts < MAX_STARTS)
                            begin
                                chunk_st[i] = CS_INTRANS;
                                start_chunk[n_starts] = i;
                                start_blk[n_starts] = first_block + blocks_done;
                                n_starts++;
                            end
                        end
                        CS_COMMITTED:
                        begin
                            blocks_done = blocks_done + 32'd1;
                            chunk_st[i] = CS_FREE;
                            log_tail = (((log_tail / CHUNK_BYTES) % NUM_BUFFERS + 1)
                                        % NUM_BUFFERS) * CHUNK_BYTES;
                            log_mem[count_pos(i)] = 8'h00;
                        end
                        CS_INTRANS:
                        begin
                            if (infl < 3)
                                infl++;
                        end
                        default:
                        begin
                        end
                    endcase
                end
                r.in_flight = 2'(infl);
            end
            OP_WRITE_DONE:
            begin
                for (int i = 0; i < NUM_BUFFERS; i++)
                begin
                    if (chunk_st[i] == CS_INTRANS)
                        chunk_st[i] = CS_COMMITTED;
                end
            end
            OP_READ:
            begin
                r.read_data = log_mem[w.ridx % BUF_BYTES];
            end
            OP_CLEAR:
            begin
                clear_log();
            end
            default:
            begin
            end
        endcase
        r.blocks_written = blocks_done;
        if (record)
        begin
            if (n_starts == 0)
            begin
                pending_results.push_back(r);
            end
            else
            begin
                for (int i = 0; i < n_starts; i++)
                begin
                    r.write_request = 1'b1;
                    r.write_chunk = 1'(start_chunk[i]);
                    r.write_block = start_blk[i];
                    r.last = (i + 1 == n_starts);
                    pending_results.push_back(r);
                end
            end
        end
    endtask

    task automatic report_mismatch(input string msg);
        $display("[%0t] result %0d: %s", $time, result_seq, msg);
        mismatch_count++;
    endtask

    task automatic compare_field(input string name, input word_t got, input word_t want);
        if (got !== want)
            report_mismatch($sformatf("%s is %0h, expected %0h", name, got, want));
    endtask

    task automatic check_result(input result_t got);
        result_t want;

        result_seq++;
        if (pending_results.size() == 0)
        begin
            report_mismatch($sformatf("unexpected result word %h", got));
            return;
        end
        want = pending_results.pop_front();
        compare_field("status", word_t'(got.status), word_t'(want.status));
        compare_field("write_request", word_t'(got.write_request),
                      word_t'(want.write_request));
        compare_field("write_chunk", word_t'(got.write_chunk), word_t'(want.write_chunk));
        compare_field("write_block", got.write_block, want.write_block);
        compare_field("in_flight", word_t'(got.in_flight), word_t'(want.in_flight));
        compare_field("read_data", word_t'(got.read_data), word_t'(want.read_data));
        compare_field("blocks_written", got.blocks_written, want.blocks_written);
        compare_field("last", word_t'(got.last), word_t'(want.last));
    endtask

    // Both channels are sampled at the rising edge. An accepted input word
    // updates the predictor at once; typed directed rows queue their written
    // result instead of the predicted one.
    always @(posedge clk)
    begin
        result_t typed_res;

        if (rst_n)
        begin
            if (in_valid && !in_stall)
            begin
                predict_word(cur_word, !cur_word.typed);
                if (cur_word.typed)
                begin
                    typed_res = '0;
                    typed_res.status = cur_word.exp_status;
                    typed_res.read_data = cur_word.exp_data;
                    typed_res.last = 1'b1;
                    pending_results.push_back(typed_res);
                end
            end
            if (out_valid && !out_stall)
            begin
                check_result({status, write_request, write_chunk, write_block,
                              in_flight, read_data, blocks_written, last});
            end
        end
    end

    // The receiver stalls at random, at the rate of the current phase.
    always @(negedge clk)
    begin
        out_stall <= rst_n && ($urandom_range(0, 99) < out_stall_pct);
    end

    // A hung block ends the run here.
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("Timeout after %0d cycles, %0d results outstanding",
                     cycle_count, pending_results.size());
            $display("Test completed with failures");
            $finish;
        end
    end

    // Offers one word, starting and ending at a falling edge. Idle cycles go
    // before it at the phase's rate; the word is then held until accepted.
    task automatic send_word(input stim_word_t w);
        while ($urandom_range(0, 99) < in_idle_pct)
        begin
            in_valid <= 1'b0;
            @(negedge clk);
        end
        cur_word <= w;
        in_valid <= 1'b1;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        @(negedge clk);
    endtask

    // Holds the sender back until every owed result word has come out.
    task automatic wait_drained();
        in_valid <= 1'b0;
        while (pending_results.size() != 0)
            @(negedge clk);
    endtask

    // The start block is only written with the block idle.
    task automatic write_start_block(input word_t value);
        wait_drained();
        cfg_wr_data <= value;
        cfg_wr_en <= 1'b1;
        @(negedge clk);
        cfg_wr_en <= 1'b0;
        first_block = value;
    endtask

    // Random word of a given operation. Half the read addresses aim at the
    // count bytes or at the packets just behind the head, where data lives.
    function automatic stim_word_t rand_word(input logic [2:0] op);
        stim_word_t w;

        w = '0;
        w.op = op;
        w.sid = 8'($urandom);
        w.ax = $urandom;
        w.ay = $urandom;
        w.acc = 1'($urandom_range(0, 1));
        if ($urandom_range(0, 1) == 0)
        begin
            w.ridx = 10'($urandom);
        end
        else
        begin
            case ($urandom_range(0, 2))
                0:       w.ridx = 10'(CHUNK_BYTES - 1);
                1:       w.ridx = 10'(BUF_BYTES - 1);
                default: w.ridx = 10'(log_head - 1 - $urandom_range(0, 3 * PACKET_BYTES));
            endcase
        end
        return w;
    endfunction

    // Random traffic built from episodes: runs of pushes that fill chunks,
    // short service and write-done sequences, noise over every code, and an
    // occasional clear. With fill_both the phase opens by filling both chunks
    // from empty, so that one service starts two writes after a refused one.
    task automatic run_random_phase(input int budget, input bit fill_both);
        int         sent;
        int         kind;
        int         k;
        stim_word_t w;

        sent = 0;
        if (fill_both)
        begin
            send_word(rand_word(OP_CLEAR));
            k = 0;
            while (!(chunk_st[0] == CS_LOCKED && chunk_st[1] == CS_LOCKED)
                   && k < PACKETS_PER_PAIR + 4)
            begin
                send_word(rand_word(OP_PUSH));
                k++;
            end
            w = rand_word(OP_SERVICE);
            w.acc = 1'b0;
            send_word(w);
            w.acc = 1'b1;
            send_word(w);
            send_word(rand_word(OP_SERVICE));
            send_word(rand_word(OP_WRITE_DONE));
            w = rand_word(OP_SERVICE);
            w.acc = 1'b1;
            send_word(w);
            sent = k + 6;
        end
        while (sent < budget)
        begin
            kind = $urandom_range(0, 99);
            if (kind < 50)
            begin
                repeat ($urandom_range(10, 70))
                begin
                    send_word(rand_word(($urandom_range(0, 9) == 0) ? OP_READ : OP_PUSH));
                    sent++;
                end
            end
            else if (kind < 77)
            begin
                repeat (4)
                begin
                    w = rand_word(($urandom_range(0, 99) < 55) ? OP_SERVICE : OP_WRITE_DONE);
                    w.acc = ($urandom_range(0, 99) < 80);
                    send_word(w);
                    sent++;
                end
            end
            else if (kind < 97)
            begin
                repeat (8)
                begin
                    w = rand_word(3'($urandom_range(0, 7)));
                    // Most clears in noise become reads, so chunks still fill.
                    if (w.op == OP_CLEAR && $urandom_range(0, 3) != 0)
                        w.op = OP_READ;
                    send_word(w);
                    sent++;
                end
            end
            else
            begin
                send_word(rand_word(OP_CLEAR));
                sent++;
            end
            if ($urandom_range(0, 99) < 8)
                wait_drained();
        end
    endtask

    // Four phases with different idle and stall rates. Each opens with the
    // block drained and a new start block: the top value, zero, a value that
    // wraps within two blocks, and a random one.
    initial
    begin
        clear_log();
        repeat (4) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        for (int phase = 0; phase < 4; phase++)
        begin
            case (phase)
                0:
                begin
                    in_idle_pct = 0;
                    out_stall_pct = 0;
                    write_start_block(32'hFFFF_FFFF);
                    for (int row = 0; row < DIRECTED_ROWS; row++)
                    begin
                        send_word(DIRECTED[row]);
                    end
                    run_random_phase(RANDOM_PER_PHASE, 1'b0);
                end
                1:
                begin
                    in_idle_pct = 51;
                    out_stall_pct = 0;
                    write_start_block(32'h0000_0000);
                    run_random_phase(RANDOM_PER_PHASE, 1'b1);
                end
                2:
                begin
                    in_idle_pct = 0;
                    out_stall_pct = 51;
                    write_start_block(32'hFFFF_FFFE);
                    run_random_phase(RANDOM_PER_PHASE, 1'b0);
                end
                default:
                begin
                    in_idle_pct = 22;
                    out_stall_pct = 22;
                    write_start_block($urandom);
                    run_random_phase(RANDOM_PER_PHASE, 1'b1);
                end
            endcase
        end
        wait_drained();
        // Wait on so that a stray extra word would still be seen.
        repeat (DRAIN_CYCLES) @(negedge clk);
        if (pending_results.size() != 0)
            report_mismatch($sformatf("%0d result words never came",
                                      pending_results.size()));
        if (mismatch_count == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

endmodule
